@@ rtl/gtep_pkg.sv @@
// ----------------------------------------------------------------------------
// gtep_pkg
// Shared types and codes for the tree entry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gtep_pkg;

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_NAME = 2'd1,
        PH_HASH = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    localparam logic [1:0] K_NAME  = 2'd0;
    localparam logic [1:0] K_HASH  = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;
    localparam logic [1:0] K_END   = 2'd3;

    localparam logic [1:0] E_NONE         = 2'd0;
    localparam logic [1:0] E_LEADING_ZERO = 2'd1;
    localparam logic [1:0] E_EXPECT_SPACE = 2'd2;
    localparam logic [1:0] E_HASH_TRUNC   = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [31:0] MODE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        entry_done;
        logic [31:0] entry_mode;
        logic [1:0]  error_code;
        logic        text_done;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/git_tree_entry_parser.sv @@
// An accepted byte goes through the input register and the parse stage into the output register.
// Throughput: one byte per cycle when not stalled; bytes that yield no result still take one slot.
// A held output stalls the parse stage, which backs up through the input register.
// Reset (synchronous, active low) empties both stages, returns the parser to the
// mode phase with a cleared mode and hash count, and clears strict_mode.
// ----------------------------------------------------------------------------
// git_tree_entry_parser
// Byte-stream tree object parser: octal mode, name, hash, with error recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module git_tree_entry_parser import gtep_pkg::*; #(
    parameter int HASH_BYTES = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_entry_done,
    output logic [31:0]      o_entry_mode,
    output logic [1:0]       o_error_code,
    output logic             o_text_done
);

    localparam int CW = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

    logic          r_strict;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;
    t_phase        r_phase;
    t_phase        n_phase;
    logic [31:0]   r_mode_acc;
    logic [31:0]   n_mode_acc;
    logic [CW-1:0] r_hash_count;
    logic [CW-1:0] n_hash_count;
    logic          r_entry_start;
    logic          n_entry_start;
    logic          r_out_valid;
    t_result       r_out;
    t_result       step_result;
    logic          step_has_result;
    logic          fire;
    logic          in_accept;

    gtep_step #(
        .HASH_BYTES (HASH_BYTES),
        .CW         (CW)
    ) u_step (
        .i_strict_mode (r_strict),
        .i_byte_value  (r_in_byte),
        .i_last_byte   (r_in_last),
        .i_phase       (r_phase),
        .i_mode_acc    (r_mode_acc),
        .i_hash_count  (r_hash_count),
        .i_entry_start (r_entry_start),
        .o_phase       (n_phase),
        .o_mode_acc    (n_mode_acc),
        .o_hash_count  (n_hash_count),
        .o_entry_start (n_entry_start),
        .o_has_result  (step_has_result),
        .o_result      (step_result)
    );

    // parse stage moves when its result (if any) has room
    assign fire      = r_in_valid && (!step_has_result || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_strict <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || fire) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_MODE;
            r_mode_acc    <= '0;
            r_hash_count  <= '0;
            r_entry_start <= 1'b1;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_mode_acc    <= n_mode_acc;
            r_hash_count  <= n_hash_count;
            r_entry_start <= n_entry_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && step_has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && step_has_result) begin
            r_out <= step_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_data_byte  = r_out.data_byte;
    assign o_entry_done = r_out.entry_done;
    assign o_entry_mode = r_out.entry_mode;
    assign o_error_code = r_out.error_code;
    assign o_text_done  = r_out.text_done;

endmodule

`default_nettype wire

@@ rtl/gtep_step.sv @@
// ----------------------------------------------------------------------------
// gtep_step
// One parse step: next phase, mode, hash count and the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gtep_step import gtep_pkg::*; #(
    parameter int HASH_BYTES = 20,
    parameter int CW         = 5
) (
    input  wire logic          i_strict_mode,
    input  wire logic [7:0]    i_byte_value,
    input  wire logic          i_last_byte,
    input  wire t_phase        i_phase,
    input  wire logic [31:0]   i_mode_acc,
    input  wire logic [CW-1:0] i_hash_count,
    input  wire logic          i_entry_start,
    output t_phase             o_phase,
    output logic [31:0]        o_mode_acc,
    output logic [CW-1:0]      o_hash_count,
    output logic               o_entry_start,
    output logic               o_has_result,
    output t_result            o_result
);

    localparam logic [CW-1:0] CNT_LAST = CW'(HASH_BYTES - 1);

    logic        raise;
    logic [1:0]  code;
    logic        clr;
    logic [31:0] acc_next;

    always_comb begin
        if (i_mode_acc[31:29] != 3'b000) begin
            acc_next = MODE_MAX;
        end else begin
            acc_next = {i_mode_acc[28:0], i_byte_value[2:0]};
        end
    end

    always_comb begin
        o_phase       = i_phase;
        o_mode_acc    = i_mode_acc;
        o_hash_count  = i_hash_count;
        o_entry_start = i_entry_start;
        o_has_result  = 1'b0;
        o_result      = '0;
        raise         = 1'b0;
        code          = E_NONE;
        clr           = 1'b0;

        case (i_phase)
            PH_MODE: begin
                if (i_entry_start && i_strict_mode && i_byte_value == CH_ZERO) begin
                    raise = 1'b1;
                    code  = E_LEADING_ZERO;
                end else if (i_byte_value inside {[CH_ZERO:CH_SEVEN]}) begin
                    o_mode_acc    = acc_next;
                    o_entry_start = 1'b0;
                    if (i_last_byte) begin
                        raise = 1'b1;
                        code  = E_EXPECT_SPACE;
                    end
                end else if (i_byte_value == CH_SPACE) begin
                    if (i_last_byte) begin
                        raise = 1'b1;
                        code  = E_HASH_TRUNC;
                    end else begin
                        o_phase       = PH_NAME;
                        o_entry_start = 1'b0;
                    end
                end else begin
                    raise = 1'b1;
                    code  = E_EXPECT_SPACE;
                end
            end
            PH_NAME: begin
                if (i_last_byte) begin
                    raise = 1'b1;
                    code  = E_HASH_TRUNC;
                end else if (i_byte_value == CH_NUL) begin
                    o_phase      = PH_HASH;
                    o_hash_count = '0;
                end else begin
                    o_has_result       = 1'b1;
                    o_result.kind      = K_NAME;
                    o_result.data_byte = i_byte_value;
                end
            end
            PH_HASH: begin
                if (i_hash_count == CNT_LAST) begin
                    o_has_result        = 1'b1;
                    o_result.kind       = K_HASH;
                    o_result.data_byte  = i_byte_value;
                    o_result.entry_done = 1'b1;
                    o_result.entry_mode = i_mode_acc;
                    o_result.text_done  = i_last_byte;
                    clr                 = 1'b1;
                end else if (i_last_byte) begin
                    raise = 1'b1;
                    code  = E_HASH_TRUNC;
                end else begin
                    o_hash_count       = i_hash_count + 1'b1;
                    o_has_result       = 1'b1;
                    o_result.kind      = K_HASH;
                    o_result.data_byte = i_byte_value;
                end
            end
            PH_DROP: begin
                if (i_last_byte) begin
                    o_has_result       = 1'b1;
                    o_result.kind      = K_END;
                    o_result.text_done = 1'b1;
                    clr                = 1'b1;
                end
            end
            default: begin
                o_phase = PH_DROP;
            end
        endcase

        if (raise) begin
            o_has_result        = 1'b1;
            o_result            = '0;
            o_result.kind       = K_ERROR;
            o_result.error_code = code;
            o_result.text_done  = i_last_byte;
            if (i_last_byte) begin
                clr = 1'b1;
            end else begin
                o_phase = PH_DROP;
            end
        end

        if (clr) begin
            o_phase       = PH_MODE;
            o_mode_acc    = '0;
            o_hash_count  = '0;
            o_entry_start = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gtep_checker.sv @@
// ----------------------------------------------------------------------------
// gtep_checker
// Port-level checks on the tree entry parser's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module gtep_checker import gtep_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_entry_done,
    input wire logic [31:0] o_entry_mode,
    input wire logic [1:0]  o_error_code,
    input wire logic        o_text_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_data_byte)
            && $stable(o_entry_mode) && $stable(o_text_done))
        else $error("result changed while stalled");

    a_done_is_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_done |-> o_kind == K_HASH)
        else $error("entry end on a non-hash result");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_ERROR |-> o_error_code == E_NONE)
        else $error("error code without error result");

    a_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_END |-> o_text_done && o_data_byte == 8'h00)
        else $error("end result without text end");

    a_mode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_done |-> o_entry_mode == 32'h0)
        else $error("mode shown outside entry end");

endmodule

bind git_tree_entry_parser gtep_checker u_gtep_checker (.*);

`default_nettype wire
